>>> hdl/plist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared codes, control word layout and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
package plist_pkg;

   typedef enum logic [2:0] {
      F_APPEND  = 3'd0,
      F_READ    = 3'd1,
      F_DUMP    = 3'd2,
      F_REMOVE  = 3'd3,
      F_CLEAR   = 3'd4,
      F_FIRST   = 3'd5,
      F_LAST    = 3'd6,
      F_INVALID = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD     = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   // Microprogram addresses.
   typedef enum logic [3:0] {
      U_IDLE       = 4'd0,
      U_BAD        = 4'd1,
      U_FULL       = 4'd2,
      U_UNKNOWN    = 4'd3,
      U_APPEND     = 4'd4,
      U_CLEAR      = 4'd5,
      U_READ       = 4'd6,
      U_READ_OUT   = 4'd7,
      U_DUMP_FIRST = 4'd8,
      U_DUMP_LOOP  = 4'd9,
      U_RM_RD      = 4'd10,
      U_RM_SAVE    = 4'd11,
      U_RM_SHIFT   = 4'd12
   } upc_type;

   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_APPEND = 2'd1,
      WR_SHIFT  = 2'd2
   } wr_type;

   typedef enum logic [1:0] {
      CNT_HOLD     = 2'd0,
      CNT_INC      = 2'd1,
      CNT_CLR      = 2'd2,
      CNT_DEC_COND = 2'd3
   } cnt_type;

   typedef enum logic [1:0] {
      EM_NONE      = 2'd0,
      EM_LAST      = 2'd1,
      EM_COND_LAST = 2'd2,
      EM_ON_COND   = 2'd3
   } emit_type;

   typedef enum logic [1:0] {
      VS_ZERO  = 2'd0,
      VS_RDATA = 2'd1,
      VS_HOLD  = 2'd2
   } vsel_type;

   typedef enum logic [1:0] {
      CD_ALWAYS   = 2'd0,
      CD_DUMP_END = 2'd1,
      CD_RM_END   = 2'd2
   } cond_type;

   typedef struct packed {
      logic       rd_en;
      logic       ptr_inc;
      logic       hold_en;
      wr_type     wr;
      cnt_type    cnt;
      emit_type   emit;
      vsel_type   vsel;
      status_type status;
      cond_type   cond;
      upc_type    target;
      logic       hit;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic pos_bad;
      logic dump_end;
      logic rm_end;
   } flags_type;

   // Control store. A step whose condition is false repeats itself.
   function automatic ctrl_type plist_ucode(input upc_type step);
      ctrl_type cw;
      cw        = '0;
      cw.target = U_IDLE;
      cw.cond   = CD_ALWAYS;
      unique case (step)
         U_IDLE: begin
            cw.target = U_IDLE;
         end
         U_BAD: begin
            cw.emit   = EM_LAST;
            cw.status = ST_BAD;
         end
         U_FULL: begin
            cw.emit   = EM_LAST;
            cw.status = ST_FULL;
         end
         U_UNKNOWN: begin
            cw.emit   = EM_LAST;
            cw.status = ST_UNKNOWN;
         end
         U_APPEND: begin
            cw.wr   = WR_APPEND;
            cw.cnt  = CNT_INC;
            cw.emit = EM_LAST;
         end
         U_CLEAR: begin
            cw.cnt  = CNT_CLR;
            cw.emit = EM_LAST;
         end
         U_READ: begin
            cw.rd_en  = 1'b1;
            cw.target = U_READ_OUT;
         end
         U_READ_OUT: begin
            cw.emit = EM_LAST;
            cw.vsel = VS_RDATA;
         end
         U_DUMP_FIRST: begin
            cw.rd_en   = 1'b1;
            cw.ptr_inc = 1'b1;
            cw.target  = U_DUMP_LOOP;
         end
         U_DUMP_LOOP: begin
            cw.rd_en   = 1'b1;
            cw.ptr_inc = 1'b1;
            cw.emit    = EM_COND_LAST;
            cw.vsel    = VS_RDATA;
            cw.cond    = CD_DUMP_END;
         end
         U_RM_RD: begin
            cw.rd_en   = 1'b1;
            cw.ptr_inc = 1'b1;
            cw.target  = U_RM_SAVE;
         end
         U_RM_SAVE: begin
            cw.rd_en   = 1'b1;
            cw.ptr_inc = 1'b1;
            cw.hold_en = 1'b1;
            cw.target  = U_RM_SHIFT;
         end
         U_RM_SHIFT: begin
            cw.rd_en   = 1'b1;
            cw.ptr_inc = 1'b1;
            cw.wr      = WR_SHIFT;
            cw.cnt     = CNT_DEC_COND;
            cw.emit    = EM_ON_COND;
            cw.vsel    = VS_HOLD;
            cw.cond    = CD_RM_END;
         end
         default: begin
            cw.target = U_IDLE;
         end
      endcase
      return cw;
   endfunction

   // Entry point of the microprogram for a new request.
   function automatic upc_type plist_dispatch(input func_type func, input flags_type fl);
      upc_type entry;
      unique case (func) inside
         F_APPEND:         entry = fl.full    ? U_FULL : U_APPEND;
         F_READ:           entry = fl.pos_bad ? U_BAD  : U_READ;
         F_DUMP:           entry = fl.empty   ? U_BAD  : U_DUMP_FIRST;
         F_REMOVE:         entry = fl.pos_bad ? U_BAD  : U_RM_RD;
         F_CLEAR:          entry = U_CLEAR;
         F_FIRST, F_LAST:  entry = fl.empty   ? U_BAD  : U_READ;
         F_INVALID:        entry = U_UNKNOWN;
         default:          entry = U_UNKNOWN;
      endcase
      return entry;
   endfunction

endpackage
`default_nettype wire

>>> hdl/plist_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/plist_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list sequencer
// Step counter over the control store, with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module plist_seq
   import plist_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] req_func,
   input  wire flags_type  flags,
   output logic            busy,
   output logic            accept,
   output ctrl_type        ctrl
);

   upc_type  upc_ff;
   upc_type  upc_in;
   ctrl_type rom_word;
   logic     cond_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      rom_word = plist_ucode(upc_ff);
      unique case (rom_word.cond)
         CD_ALWAYS:   cond_hit = 1'b1;
         CD_DUMP_END: cond_hit = flags.dump_end;
         CD_RM_END:   cond_hit = flags.rm_end;
         default:     cond_hit = 1'b1;
      endcase
      ctrl     = rom_word;
      ctrl.hit = cond_hit;
      busy     = (upc_ff != U_IDLE);
      accept   = start && !busy;
      upc_in   = upc_ff;
      if (upc_ff == U_IDLE) begin
         if (start) begin
            upc_in = plist_dispatch(func_type'(req_func), flags);
         end
      end else if (cond_hit) begin
         upc_in = rom_word.target;
      end
   end

endmodule
`default_nettype wire

>>> hdl/plist_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list datapath
// Entry memory, count, pointer and the registered result outputs.
// ----------------------------------------------------------------------------
module plist_dp
   import plist_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic        [2:0]  req_func,
   input  wire logic signed [31:0] req_value_in,
   input  wire logic        [5:0]  req_position,
   input  wire ctrl_type           ctrl,
   output flags_type               flags,
   output logic                    rsp_strobe,
   output logic signed      [31:0] rsp_value_out,
   output logic             [1:0]  rsp_status,
   output logic                    rsp_last_of_run
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH + 2);

   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [31:0]   value_ff;
   logic [31:0]   hold_ff;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          fire;
   logic          fire_last;
   logic [31:0]   out_value;

   logic          rsp_strobe_ff;
   logic [31:0]   rsp_value_ff;
   status_type    rsp_status_ff;
   logic          rsp_last_ff;

   plist_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctrl.rd_en),
      .rd_addr(ptr_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      flags.empty    = (count_ff == '0);
      flags.full     = (count_ff == CW'(DEPTH));
      flags.pos_bad  = (req_position == 6'd0) || (int'(req_position) > int'(count_ff));
      flags.dump_end = (ptr_ff == PW'(count_ff));
      // The shift is done once the write slot reaches the old tail.
      flags.rm_end   = (ptr_ff == PW'(count_ff) + PW'(1));
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (accept) begin
         unique case (func_type'(req_func)) inside
            F_READ, F_REMOVE: ptr_in = PW'(req_position - 6'd1);
            F_LAST:           ptr_in = PW'(count_ff - CW'(1));
            default:          ptr_in = '0;
         endcase
      end else if (ctrl.ptr_inc) begin
         ptr_in = ptr_ff + PW'(1);
      end

      unique case (ctrl.cnt)
         CNT_HOLD:     count_in = count_ff;
         CNT_INC:      count_in = count_ff + CW'(1);
         CNT_CLR:      count_in = '0;
         CNT_DEC_COND: count_in = ctrl.hit ? count_ff - CW'(1) : count_ff;
         default:      count_in = count_ff;
      endcase

      wr_en = (ctrl.wr != WR_NONE);
      unique case (ctrl.wr)
         WR_APPEND: begin
            wr_addr = AW'(count_ff);
            wr_data = value_ff;
         end
         WR_SHIFT: begin
            wr_addr = AW'(ptr_ff - PW'(2));
            wr_data = rd_data;
         end
         default: begin
            wr_addr = AW'(count_ff);
            wr_data = rd_data;
         end
      endcase

      fire      = (ctrl.emit == EM_LAST) || (ctrl.emit == EM_COND_LAST) ||
                  ((ctrl.emit == EM_ON_COND) && ctrl.hit);
      fire_last = (ctrl.emit == EM_LAST) || ctrl.hit;

      unique case (ctrl.vsel)
         VS_RDATA: out_value = rd_data;
         VS_HOLD:  out_value = hold_ff;
         default:  out_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (accept) begin
         value_ff <= req_value_in;
      end
      if (ctrl.hold_en) begin
         hold_ff <= rd_data;
      end
      if (fire) begin
         rsp_value_ff  <= out_value;
         rsp_status_ff <= ctrl.status;
         rsp_last_ff   <= fire_last;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !wr_en && !fire)
      else $error("datapath active while a request is taken");
`endif

endmodule
`default_nettype wire

>>> hdl/positional_list_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with append, positional read and
// remove, dump, clear, first and last.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low;
// req_func, req_value_in and req_position are sampled on that edge. The
// block handles one request at a time and holds busy high until its last
// step has run.
// Each result shows on the rsp_ ports for exactly one cycle with rsp_strobe
// high; rsp_last_of_run marks the final result of a request. The receiver
// cannot stall, so results are never held back.
// Append, clear and every error emit from the step they dispatch to; read,
// first and last read the entry in U_READ and emit it in U_READ_OUT.
// A dump of N entries reads in U_DUMP_FIRST, then gives one result per
// cycle in U_DUMP_LOOP. A remove at position p moves each later entry down
// in U_RM_SHIFT, paced by the single write port of the entry memory.
// A new request can be taken in the cycle the last result is shown.
// Reset empties the list at once; no memory sweep is needed.
// ----------------------------------------------------------------------------
module positional_list_engine_top
   import plist_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [2:0]  req_func,
   input  wire logic signed [31:0] req_value_in,
   input  wire logic        [5:0]  req_position,
   output logic                    rsp_strobe,
   output logic signed      [31:0] rsp_value_out,
   output logic             [1:0]  rsp_status,
   output logic                    rsp_last_of_run
);

   flags_type flags;
   ctrl_type  ctrl;
   logic      accept;

   plist_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_func(req_func),
      .flags   (flags),
      .busy    (busy),
      .accept  (accept),
      .ctrl    (ctrl)
   );

   plist_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_func       (req_func),
      .req_value_in   (req_value_in),
      .req_position   (req_position),
      .ctrl           (ctrl),
      .flags          (flags),
      .rsp_strobe     (rsp_strobe),
      .rsp_value_out  (rsp_value_out),
      .rsp_status     (rsp_status),
      .rsp_last_of_run(rsp_last_of_run)
   );

`ifndef ASSERT_OFF
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_run) |-> !busy)
      else $error("final result shown while still busy");

   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_of_run) |-> busy)
      else $error("partial result shown while idle");
`endif

endmodule
`default_nettype wire
